// ----- design/mp4_init_segment_finder_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the init segment finder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MP4_INIT_SEGMENT_FINDER_TOP_MACROS_SVH
`define MP4_INIT_SEGMENT_FINDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define MP4ISF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mp4isf assertion failed");
// Next-cycle implication.
`define MP4ISF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mp4isf assertion failed");
`else
`define MP4ISF_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MP4ISF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- design/mp4isf_pkg.sv -----
// ----------------------------------------------------------------------------
// mp4isf_pkg
// Shared types and constants of the init segment finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mp4isf_pkg;

  localparam int OFF_W = 32;
  localparam int SIZE_W = 64;
  localparam int SUM_W = SIZE_W + 1;

  localparam logic [SUM_W-1:0] OFF_LIMIT = SUM_W'(1) << OFF_W;

  localparam logic [31:0] TYPE_MOOV = 32'h6D6F_6F76;
  localparam logic [31:0] TYPE_MOOF = 32'h6D6F_6F66;

  localparam logic [3:0] HDR_SIZE_LAST  = 4'd3;
  localparam logic [3:0] HDR_SHORT_LAST = 4'd7;
  localparam logic [3:0] HDR_LONG_LAST  = 4'd15;

  localparam logic [SIZE_W-1:0] SIZE_LARGE     = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_SHORT_MIN = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] SIZE_LONG_MIN  = SIZE_W'(16);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_FOUND  = 2'd2,
    PH_STALL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_SCAN  = 2'd0,
    ST_FOUND = 2'd1,
    ST_STALL = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
  } result_t;

endpackage

`default_nettype wire

// ----- design/mp4isf_walker.sv -----
// ----------------------------------------------------------------------------
// mp4isf_walker
// Box header parser and body skipper, one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mp4_init_segment_finder_top_macros.svh"

module mp4isf_walker
  import mp4isf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] stream_byte,
  output result_t         result_next
);

  logic [OFF_W-1:0]  byte_position, byte_position_next;
  logic [OFF_W-1:0]  box_start, box_start_next;
  logic [3:0]        header_index, header_index_next;
  logic [SIZE_W-1:0] size_accumulator, size_accumulator_next;
  logic [31:0]       type_word, type_word_next;
  logic [OFF_W:0]    box_end, box_end_next;
  logic              moov_seen, moov_seen_next;
  phase_t            phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      box_start        <= '0;
      header_index     <= '0;
      size_accumulator <= '0;
      type_word        <= '0;
      box_end          <= '0;
      moov_seen        <= 1'b0;
      phase            <= PH_HEADER;
    end else if (step) begin
      byte_position    <= byte_position_next;
      box_start        <= box_start_next;
      header_index     <= header_index_next;
      size_accumulator <= size_accumulator_next;
      type_word        <= type_word_next;
      box_end          <= box_end_next;
      moov_seen        <= moov_seen_next;
      phase            <= phase_next;
    end
  end

  // next state
  always_comb begin
    logic [OFF_W:0]    next_pos;
    logic [SIZE_W-1:0] set_size;
    logic [SUM_W-1:0]  sum;
    logic              do_set;
    logic              do_finish;
    logic [OFF_W:0]    fin_end;
    logic [31:0]       fin_type;

    byte_position_next    = byte_position;
    box_start_next        = box_start;
    header_index_next     = header_index;
    size_accumulator_next = size_accumulator;
    type_word_next        = type_word;
    box_end_next          = box_end;
    moov_seen_next        = moov_seen;
    phase_next            = phase;

    next_pos  = {1'b0, byte_position} + (OFF_W+1)'(1);
    set_size  = size_accumulator;
    do_set    = 1'b0;
    do_finish = 1'b0;
    fin_end   = box_end;
    fin_type  = type_word;

    unique case (phase)
      PH_BODY: begin
        byte_position_next = next_pos[OFF_W-1:0];
        if (next_pos >= box_end) begin
          do_finish = 1'b1;
        end
      end
      PH_HEADER: begin
        byte_position_next = next_pos[OFF_W-1:0];
        header_index_next  = header_index + 4'd1;
        if (header_index <= HDR_SIZE_LAST) begin
          size_accumulator_next = {32'b0, size_accumulator[23:0], stream_byte};
        end else if (header_index <= HDR_SHORT_LAST) begin
          type_word_next = {type_word[23:0], stream_byte};
          fin_type       = type_word_next;
          if (header_index == HDR_SHORT_LAST) begin
            if (size_accumulator == SIZE_LARGE) begin
              size_accumulator_next = '0;
            end else if (size_accumulator < SIZE_SHORT_MIN) begin
              phase_next = PH_STALL;
            end else begin
              do_set = 1'b1;
            end
          end
        end else begin
          size_accumulator_next = {size_accumulator[SIZE_W-9:0], stream_byte};
          set_size              = size_accumulator_next;
          if (header_index == HDR_LONG_LAST) begin
            if (size_accumulator_next < SIZE_LONG_MIN) begin
              phase_next = PH_STALL;
            end else begin
              do_set = 1'b1;
            end
          end
        end
      end
      default: begin
        // hold the answer; the byte is dropped
      end
    endcase

    // A header-only box completes on its last header byte.
    sum = SUM_W'(box_start) + SUM_W'(set_size);
    if (do_set) begin
      if (sum > OFF_LIMIT) begin
        phase_next = PH_STALL;
      end else begin
        box_end_next = sum[OFF_W:0];
        fin_end      = sum[OFF_W:0];
        if ((header_index == HDR_SHORT_LAST && set_size == SIZE_SHORT_MIN) ||
            (header_index == HDR_LONG_LAST && set_size == SIZE_LONG_MIN)) begin
          do_finish = 1'b1;
        end else begin
          phase_next = PH_BODY;
        end
      end
    end

    if (do_finish) begin
      if (fin_type == TYPE_MOOF) begin
        phase_next = moov_seen ? PH_FOUND : PH_STALL;
      end else begin
        if (fin_type == TYPE_MOOV) begin
          moov_seen_next = 1'b1;
        end
        if (fin_end[OFF_W]) begin
          phase_next = PH_STALL;
        end else begin
          box_start_next        = fin_end[OFF_W-1:0];
          header_index_next     = '0;
          size_accumulator_next = '0;
          type_word_next        = '0;
          box_end_next          = '0;
          phase_next            = PH_HEADER;
        end
      end
    end
  end

  // outputs
  always_comb begin
    result_next.offset = '0;
    unique case (phase_next)
      PH_FOUND: begin
        result_next.status = ST_FOUND;
        result_next.offset = 32'(box_start_next);
      end
      PH_STALL: result_next.status = ST_STALL;
      default:  result_next.status = ST_SCAN;
    endcase
  end

  `MP4ISF_ASSERT_NEXT(a_found_holds, clk, rst, phase == PH_FOUND, phase == PH_FOUND)
  `MP4ISF_ASSERT_NEXT(a_stall_holds, clk, rst, phase == PH_STALL, phase == PH_STALL)
  `MP4ISF_ASSERT_NEXT(a_moov_sticky, clk, rst, moov_seen, moov_seen)
  `MP4ISF_ASSERT_NOW(a_body_before_end, clk, rst, phase == PH_BODY,
                     {1'b0, byte_position} < box_end)

endmodule

`default_nettype wire

// ----- design/mp4isf_out_stage.sv -----
// ----------------------------------------------------------------------------
// mp4isf_out_stage
// Result register with valid/stall handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp4isf_out_stage
  import mp4isf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t d,
  input  wire logic    stall,
  output logic         valid,
  output result_t      q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  // payload: load only, hold otherwise
  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ----- design/mp4_init_segment_finder_top.sv -----
// ----------------------------------------------------------------------------
// mp4_init_segment_finder_top
// Walks top-level MP4 boxes byte by byte and reports where the init segment
// ends (start of the first moof after a moov).
// ----------------------------------------------------------------------------
// Result: registered; it shows on the output in the cycle after its byte is
//   accepted. Throughput: one byte per cycle while in_stall is low; the whole
//   header/body update for a byte is one register-to-register pass through
//   the walker, and the result register frees as its transaction is taken.
// Reset: synchronous, active high; walker restarts at offset zero in header
//   phase with no moov seen, and the result register empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp4_init_segment_finder_top
  import mp4isf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  stream_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       parse_status,
  output logic [31:0]      init_end_offset
);

  result_t result_next;
  result_t result_q;
  logic    step;

  // Stall the input only while a finished result waits and the sink holds it;
  // otherwise the result register takes a new transaction every cycle.
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  // Advance the box walker one byte per accepted transaction.
  mp4isf_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .stream_byte (stream_byte),
    .result_next (result_next)
  );

  // Hold each result until the sink takes it.
  mp4isf_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (step),
    .d     (result_next),
    .stall (out_stall),
    .valid (out_valid),
    .q     (result_q)
  );

  assign parse_status    = result_q.status;
  assign init_end_offset = result_q.offset;

endmodule

`default_nettype wire
